// ----- hw/rtl/ftq_pkg.sv -----
// Shared types, field widths and default sizes for the fetch target queue.
`default_nettype none

package ftq_pkg;

  // default sizes
  localparam int QueueDepthDef  = 16;
  localparam int CommitLanesDef = 4;
  localparam int PayloadBitsDef = 64;

  // fixed field widths on the stream ports
  localparam int PosW     = 4;
  localparam int MaskW    = 4;
  localparam int PayloadW = 64;
  localparam int IdxOutW  = 4;
  localparam int OccW     = 5;

  // input item, first field in the highest bits
  typedef struct packed {
    logic [PosW-1:0]     read_index;
    logic [PayloadW-1:0] alloc_payload;
    logic                alloc_valid;
    logic [MaskW-1:0]    commit_last_mask;
    logic [PosW-1:0]     recover_position;
    logic                recover;
    logic                flush;
  } ftq_in_t;

  // result item, first field in the highest bits
  typedef struct packed {
    logic [PayloadW-1:0] read_payload;
    logic                read_valid;
    logic [OccW-1:0]     occupancy;
    logic                empty_flag;
    logic                full_flag;
    logic [IdxOutW-1:0]  alloc_index;
    logic                alloc_success;
  } ftq_out_t;

  localparam int InBits     = $bits(ftq_in_t);
  localparam int OutBits    = $bits(ftq_out_t);
  localparam int InTdataW   = ((InBits + 7) / 8) * 8;
  localparam int OutTdataW  = ((OutBits + 7) / 8) * 8;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // take the input item and read the addressed entry
    logic exec;     // apply the cycle update and load the result register
  } ftq_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ftq_dp.sv -----
// Datapath: pointers, count, valid marks, entry memory and result register.
`default_nettype none

module ftq_dp #(
  parameter int QUEUE_DEPTH  = ftq_pkg::QueueDepthDef,
  parameter int COMMIT_LANES = ftq_pkg::CommitLanesDef,
  parameter int PAYLOAD_BITS = ftq_pkg::PayloadBitsDef
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ftq_pkg::ftq_cmd_t cmd,
  input  wire ftq_pkg::ftq_in_t  in_item,
  output ftq_pkg::ftq_out_t      out_item
);

  localparam int PtrW      = $clog2(QUEUE_DEPTH);
  localparam int CntW      = $clog2(QUEUE_DEPTH + 1);
  localparam int UsedLanes = (COMMIT_LANES < ftq_pkg::MaskW) ? COMMIT_LANES : ftq_pkg::MaskW;
  localparam int PopW      = $clog2(UsedLanes + 1);
  localparam int CmpW      = (PopW > CntW) ? PopW : CntW;
  localparam int PosVals   = 2 ** ftq_pkg::PosW;

  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW:0]   DepthSum = (PtrW + 1)'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast  = PtrW'(QUEUE_DEPTH - 1);

  logic [PtrW-1:0]         head;
  logic [PtrW-1:0]         tail;
  logic [CntW-1:0]         count;
  logic [QUEUE_DEPTH-1:0]  valid_marks;
  logic [PAYLOAD_BITS-1:0] mem [QUEUE_DEPTH];

  ftq_pkg::ftq_in_t        item;
  logic                    rd_valid;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  logic [PtrW-1:0] rd_addr;
  logic [PtrW-1:0] rpos;
  logic [PopW-1:0] pops;
  logic [CntW-1:0] take;
  logic [PtrW:0]   hsum;
  logic [PtrW-1:0] head_next;
  logic [PtrW-1:0] tail_mid;
  logic [CntW-1:0] count_mid;
  logic            alloc_ok;
  logic [PtrW-1:0] tail_next;
  logic [CntW-1:0] count_next;

  // 4-bit indexes wrap modulo the depth: small decode over the possible codes
  always_comb begin
    rd_addr = '0;
    rpos    = '0;
    for (int i = 0; i < PosVals; i++) begin
      if (in_item.read_index == ftq_pkg::PosW'(i)) rd_addr = PtrW'(i % QUEUE_DEPTH);
      if (item.recover_position == ftq_pkg::PosW'(i)) rpos = PtrW'(i % QUEUE_DEPTH);
    end
  end

  always_comb begin
    pops = '0;
    for (int i = 0; i < UsedLanes; i++) begin
      pops = pops + PopW'(item.commit_last_mask[i]);
    end
  end

  // pops stop at empty
  always_comb begin
    take = (CmpW'(pops) > CmpW'(count)) ? count : CntW'(pops);
    hsum = {1'b0, head} + (PtrW + 1)'(take);
  end

  always_comb begin
    head_next = head;
    tail_mid  = tail;
    count_mid = count;
    if (item.flush) begin
      head_next = '0;
      tail_mid  = '0;
      count_mid = '0;
    end else if (item.recover) begin
      tail_mid = rpos;
      if (rpos >= head) count_mid = CntW'(rpos - head);
      else count_mid = DepthCnt - CntW'(head - rpos);
    end else begin
      head_next = (hsum >= DepthSum) ? PtrW'(hsum - DepthSum) : PtrW'(hsum);
      count_mid = count - take;
    end
    alloc_ok   = item.alloc_valid && (count_mid < DepthCnt);
    tail_next  = tail_mid;
    count_next = count_mid;
    if (alloc_ok) begin
      tail_next  = (tail_mid == PtrLast) ? '0 : tail_mid + 1'b1;
      count_next = count_mid + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      valid_marks <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      // on flush the tail restarts at entry 0, so only that mark can be set
      if (item.flush) valid_marks <= QUEUE_DEPTH'(alloc_ok);
      else if (alloc_ok) valid_marks[tail_mid] <= 1'b1;
    end
  end

  // entry memory: invalid entries read as zero, so flush only drops valid marks
  always_ff @(posedge clk) begin
    if (cmd.exec && alloc_ok) mem[tail_mid] <= item.alloc_payload[PAYLOAD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item       <= in_item;
      rd_valid   <= valid_marks[rd_addr];
      rd_payload <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_item.alloc_success <= alloc_ok;
      out_item.alloc_index   <= alloc_ok ? ftq_pkg::IdxOutW'(tail_mid) : '0;
      out_item.full_flag     <= (count >= DepthCnt);
      out_item.empty_flag    <= (count == '0);
      out_item.occupancy     <= ftq_pkg::OccW'(count);
      out_item.read_valid    <= rd_valid;
      out_item.read_payload  <= rd_valid ? ftq_pkg::PayloadW'(rd_payload) : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DepthCnt)
    else $error("entry count above depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    ((CntW + 1)'(head) + (CntW + 1)'(count) == (CntW + 1)'(tail)) ||
    ((CntW + 1)'(head) + (CntW + 1)'(count) == (CntW + 1)'(tail) + (CntW + 1)'(QUEUE_DEPTH)))
    else $error("head plus count does not reach tail");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && item.flush && !item.alloc_valid |=> count == '0 && head == '0 && valid_marks == '0)
    else $error("flush left state behind");

endmodule

`default_nettype wire

// ----- hw/rtl/ftq_ctrl.sv -----
// Controller: sequences capture, update and result transfer for one item at a time.
`default_nettype none

module ftq_ctrl (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  output ftq_pkg::ftq_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    HOLD
  } state_t;

  state_t state;

  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.exec    = (state == EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= EXEC;
            s_tready <= 1'b0;
          end else begin
            s_tready <= 1'b1;
          end
        end
        EXEC: begin
          state    <= HOLD;
          m_tvalid <= 1'b1;
        end
        HOLD: begin
          if (m_tready) begin
            state    <= IDLE;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          s_tready <= 1'b0;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == EXEC && !s_tready)
    else $error("accepted transfer not followed by update");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    state == EXEC |=> m_tvalid)
    else $error("update not followed by result");

  a_one_item: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input open while result pending");

endmodule

`default_nettype wire

// ----- hw/rtl/fetch_target_queue.sv -----
// Top level of the fetch target queue: stream ports, controller and datapath.
// A result follows its input transfer through capture, then update.
// The control sequence handles one item at a time: the next input transfer can follow
//   the result transfer in the cycle after it.
// Reset (rst, synchronous, active high): empty queue, pointers and count zero, every
//   entry reads as invalid with zero payload; s_tready is low and rises in the cycle after.
`default_nettype none

module fetch_target_queue #(
  parameter int QUEUE_DEPTH  = ftq_pkg::QueueDepthDef,
  parameter int COMMIT_LANES = ftq_pkg::CommitLanesDef,
  parameter int PAYLOAD_BITS = ftq_pkg::PayloadBitsDef
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata, from bit 0: flush, recover, recover_position[4], commit_last_mask[4],
  //   alloc_valid, alloc_payload[64], read_index[4], zero pad
  input  wire logic [ftq_pkg::InTdataW-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata, from bit 0: alloc_success, alloc_index[4], full_flag, empty_flag,
  //   occupancy[5], read_valid, read_payload[64], zero pad
  output logic [ftq_pkg::OutTdataW-1:0]        m_tdata
);

  localparam int OutPad = ftq_pkg::OutTdataW - ftq_pkg::OutBits;

  ftq_pkg::ftq_cmd_t cmd;
  ftq_pkg::ftq_in_t  in_item;
  ftq_pkg::ftq_out_t out_item;

  // unpack the input transfer; pad bits are dropped
  assign in_item = ftq_pkg::ftq_in_t'(s_tdata[ftq_pkg::InBits-1:0]);

  // the result register sits in the datapath and holds while the sink stalls
  assign m_tdata = {{OutPad{1'b0}}, out_item};

  // control sequence: idle/accept, update, hold result until transferred
  ftq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // queue state: flush first, else recover, else commit pops; then allocation.
  // Status and the indexed read show the state from before the update.
  ftq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .COMMIT_LANES (COMMIT_LANES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
